// ===== rtl/hce_pkg.sv =====
// Shared types, constants and helper function of the histogram counter engine.
package hce_pkg;

   localparam int NUM_BINS   = 1024;
   localparam int COUNT_BITS = 32;
   localparam int BIN_BITS   = $clog2(NUM_BINS);

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  any;
      logic [BIN_BITS-1:0]   lo;
      logic [BIN_BITS-1:0]   hi;
      logic [BIN_BITS-1:0]   mode;
      logic [COUNT_BITS-1:0] best;
   } stats_type;

   // clamp a bin count to the 32-bit result field
   function automatic logic [31:0] sat32(input logic [COUNT_BITS-1:0] v);
      logic [63:0] w;
      begin
         w = 64'(v);
         sat32 = (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
      end
   endfunction

endpackage

// ===== rtl/hce_bin_ram.sv =====
// Simple dual-port RAM, one write port and one registered read port.
module hce_bin_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hce_stats.sv =====
// Running statistics: lowest, highest and mode bin with its count.
module hce_stats (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clr,
   input  logic                           upd,
   input  logic [hce_pkg::BIN_BITS-1:0]   bin,
   input  logic [hce_pkg::COUNT_BITS-1:0] count,
   output hce_pkg::stats_type             cur,
   output hce_pkg::stats_type             nxt
);
   import hce_pkg::*;

   stats_type stats_ff;
   stats_type stats_in;

   always_comb begin
      stats_in = stats_ff;
      if (clr) begin
         stats_in = '0;
      end else if (upd) begin
         if (!stats_ff.any) begin
            stats_in.lo = bin;
            stats_in.hi = bin;
         end else begin
            if (bin < stats_ff.lo) stats_in.lo = bin;
            if (bin > stats_ff.hi) stats_in.hi = bin;
         end
         // ties go to the smaller bin
         if (!stats_ff.any || count > stats_ff.best ||
             (count == stats_ff.best && bin < stats_ff.mode)) begin
            stats_in.best = count;
            stats_in.mode = bin;
         end
         stats_in.any = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff <= '0;
      end else begin
         stats_ff <= stats_in;
      end
   end

   assign cur = stats_ff;
   assign nxt = stats_in;

endmodule

// ===== rtl/histogram_counter_engine_unit.sv =====
// Top level of the histogram counter engine: control, bin table and result register.
//
// Requests arrive on req_: tuser carries the opcode (add, read, clear), tdata the
// sample value. Each request gives exactly one response on rsp_ with the bin
// count, range and empty flags and the lowest, highest and mode statistics.
// csr_we/csr_wdata write the base value; write it only while no request is in work.
//
// For an add or read the bin is read from the table RAM in the accept cycle; an
// add writes it back with the incremented count in the next, where the response
// is loaded into the output register. One request is in work at a time, so the
// next is accepted only once the last one's response is in the output register.
// A clear request sweeps the table one bin per cycle over all NUM_BINS bins
// before its response. After reset the same sweep runs with req_tready low;
// csr writes are taken during it.
// A stalled response sits in the output register while the next request is
// accepted; that request finishes into a holding state until the slot frees.
module histogram_counter_engine_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata,     // base_value
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,     // [31:0] sample_value
   input  logic [1:0]    req_tuser,     // [1:0] opcode
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [159:0]  rsp_tdata,     // bin_count, lowest_value, highest_value,
                                        // mode_value, mode_count
   output logic [1:0]    rsp_tuser      // [0] out_of_range, [1] is_empty
);
   import hce_pkg::*;

   state_type state_ff, state_in;

   logic [31:0]           base_ff;
   logic [1:0]            op_ff;
   logic                  inr_ff;
   logic [BIN_BITS-1:0]   bin_ff;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  oor_ff, oor_in;
   logic                  pend_ff, pend_in;
   logic [BIN_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [159:0]          rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   logic                  accept;
   logic [32:0]           diff;
   logic                  inr;
   logic [BIN_BITS-1:0]   bin;
   logic [COUNT_BITS-1:0] rd_data;
   logic [COUNT_BITS-1:0] inc_sat;
   logic                  do_add;
   logic                  slot_free;
   logic                  load_rsp;
   logic                  use_nxt;
   logic                  stats_clr;
   logic                  stats_upd;
   logic                  wr_en;
   logic [BIN_BITS-1:0]   wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   stats_type             st_cur, st_nxt, st_sel;

   function automatic logic [31:0] bin_val(input logic [31:0] base,
                                           input logic [BIN_BITS-1:0] b,
                                           input logic any);
      bin_val = any ? (base + 32'(b)) : 32'h0;
   endfunction

   // range check on the 33-bit signed offset from the base
   assign diff    = {req_tdata[31], req_tdata} - {base_ff[31], base_ff};
   assign inr     = !diff[32] && (diff[31:0] < 32'(NUM_BINS));
   assign bin     = diff[BIN_BITS-1:0];
   assign accept  = req_tvalid && req_tready;
   assign inc_sat = (rd_data == {COUNT_BITS{1'b1}}) ? rd_data : rd_data + 1'b1;
   assign do_add  = (op_ff == OP_ADD) && inr_ff;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cnt_in      = cnt_ff;
      oor_in      = oor_ff;
      pend_in     = pend_ff;
      clr_addr_in = clr_addr_ff;
      load_rsp    = 1'b0;
      use_nxt     = 1'b0;
      stats_clr   = 1'b0;
      stats_upd   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = bin_ff;
      wr_data     = inc_sat;
      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == BIN_BITS'(NUM_BINS - 1)) begin
               clr_addr_in = '0;
               state_in    = pend_ff ? ST_DONE : ST_IDLE;
               pend_in     = 1'b0;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == OP_CLEAR) begin
                  stats_clr = 1'b1;
                  cnt_in    = '0;
                  oor_in    = 1'b0;
                  pend_in   = 1'b1;
                  state_in  = ST_CLEAR;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            stats_upd = do_add;
            wr_en     = do_add && (rd_data != {COUNT_BITS{1'b1}});
            if (do_add) begin
               cnt_in = inc_sat;
            end else if ((op_ff == OP_READ) && inr_ff) begin
               cnt_in = rd_data;
            end else begin
               cnt_in = '0;
            end
            oor_in = ((op_ff == OP_ADD) || (op_ff == OP_READ)) && !inr_ff;
            if (slot_free) begin
               load_rsp = 1'b1;
               use_nxt  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign st_sel = use_nxt ? st_nxt : st_cur;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(st_sel.any ? sat32(st_sel.best) : 32'h0),
                         bin_val(base_ff, st_sel.mode, st_sel.any),
                         bin_val(base_ff, st_sel.hi, st_sel.any),
                         bin_val(base_ff, st_sel.lo, st_sel.any),
                         sat32(cnt_in)};
         rsp_user_in  = {!st_sel.any, oor_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= 32'h0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      oor_ff      <= oor_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (accept) begin
         op_ff  <= req_tuser;
         inr_ff <= inr;
         bin_ff <= bin;
      end
   end

   hce_bin_ram #(
      .DEPTH (NUM_BINS),
      .WIDTH (COUNT_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (bin),
      .rd_data (rd_data)
   );

   hce_stats u_stats (
      .clock (clock),
      .reset (reset),
      .clr   (stats_clr),
      .upd   (stats_upd),
      .bin   (bin_ff),
      .count (inc_sat),
      .cur   (st_cur),
      .nxt   (st_nxt)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
